// File: sv/v3a_pkg.sv
package v3a_pkg;

	typedef enum logic [2:0] {
		OP_NEG    = 3'd0,
		OP_ADD    = 3'd1,
		OP_SUB    = 3'd2,
		OP_SCALE  = 3'd3,
		OP_DOT    = 3'd4,
		OP_CROSS  = 3'd5,
		OP_TRIPLE = 3'd6,
		OP_XFORM  = 3'd7
	} op_t;

	localparam logic [1:0] REG_ROW0 = 2'd0;
	localparam logic [1:0] REG_ROW1 = 2'd1;
	localparam logic [1:0] REG_ROW2 = 2'd2;

	localparam int ROW_W  = 48;
	localparam int COEF_W = 16;
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	// three truncated Q16.16 products need 50 bits, keep some margin
	localparam int SUM_W  = 52;

	localparam int Q_SHIFT = 16;
	localparam int M_SHIFT = 14;

	localparam logic [ROW_W-1:0] ROW0_RST = 48'h0000_0000_4000;
	localparam logic [ROW_W-1:0] ROW1_RST = 48'h0000_4000_0000;
	localparam logic [ROW_W-1:0] ROW2_RST = 48'h4000_0000_0000;

	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              clip;
	} sat_t;

	function automatic sat_t sat32(input logic [SUM_W-1:0] x);
		sat_t r;
		r.clip = !((&x[SUM_W-1:DATA_W-1]) || !(|x[SUM_W-1:DATA_W-1]));
		if (r.clip) begin
			r.val = x[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			r.val = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: sv/v3a_if.sv
interface v3a_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] a_x;
	logic [31:0] a_y;
	logic [31:0] a_z;
	logic [31:0] b_x;
	logic [31:0] b_y;
	logic [31:0] b_z;
	logic [31:0] c_x;
	logic [31:0] c_y;
	logic [31:0] c_z;
	logic [31:0] scale_factor;

	modport source (
		output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, scale_factor,
		input  ready
	);
	modport sink (
		input  valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, scale_factor,
		output ready
	);
endinterface

interface v3a_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_x;
	logic [31:0] result_y;
	logic [31:0] result_z;
	logic [31:0] scalar_result;
	logic        saturated;

	modport source (
		output valid, result_x, result_y, result_z, scalar_result, saturated,
		input  ready
	);
	modport sink (
		input  valid, result_x, result_y, result_z, scalar_result, saturated,
		output ready
	);
endinterface

// File: sv/v3a_mul_bank.sv
module v3a_mul_bank import v3a_pkg::*; #(
	parameter int N = 3
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DATA_W-1:0] opa [N],
	input  logic signed [DATA_W-1:0] opb [N],
	output logic signed [PROD_W-1:0] prod [N]
);

	logic signed [PROD_W-1:0] prod_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				prod_s[i] <= opa[i] * opb[i];
			end
		end
	end

	assign prod = prod_s;

endmodule

// File: sv/vector3_alu_with_transform_core.sv
// Fixed-point 3-vector ALU with a configurable 3x3 matrix (Q16.16 data, Q2.14 matrix).
// Channels: item (sink) carries the operation and operands a, b, c, scale_factor;
// result (source) carries result_x/y/z, scalar_result and saturated. A transfer
// happens on a clock edge with valid and ready both high.
// Matrix rows must be written through cfg_we/cfg_index/cfg_data only while the block
// is idle; the block itself does not enforce this. Indexes past the third row are ignored.
// Five register stages (operand select, first multiplier bank, sums and clamps, second
// multiplier bank for the triple product, output) carry each item to the result.
// Throughput: one item per cycle while result.ready stays high.
// When the receiver holds ready low, valid stages close up behind the output
// register and item.ready drops only once every stage holds an item; nothing is
// lost or repeated.
// Reset clears all stage valid bits and loads the identity matrix.
module vector3_alu_with_transform_core import v3a_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	v3a_in_if.sink           item,
	v3a_out_if.source        result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [ROW_W-1:0] cfg_data
);

	logic [ROW_W-1:0] row_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW0_RST;
			row_q[1] <= ROW1_RST;
			row_q[2] <= ROW2_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW0: row_q[0] <= cfg_data;
				REG_ROW1: row_q[1] <= cfg_data;
				REG_ROW2: row_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !v_s5 || result.ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign item.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= item.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// operand select
	op_t                op_in;
	logic signed [DATA_W-1:0] av [3];
	logic signed [DATA_W-1:0] bv [3];
	logic signed [DATA_W-1:0] cv [3];
	logic signed [DATA_W-1:0] uv [3];
	logic signed [DATA_W-1:0] wv [3];
	logic signed [DATA_W-1:0] opl [9];
	logic signed [DATA_W-1:0] opr [9];

	assign op_in = op_t'(item.operation);
	assign av[0] = item.a_x;
	assign av[1] = item.a_y;
	assign av[2] = item.a_z;
	assign bv[0] = item.b_x;
	assign bv[1] = item.b_y;
	assign bv[2] = item.b_z;
	assign cv[0] = item.c_x;
	assign cv[1] = item.c_y;
	assign cv[2] = item.c_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uv[i] = (op_in == OP_CROSS) ? av[i] : bv[i];
			wv[i] = (op_in == OP_CROSS) ? bv[i] : cv[i];
		end
		for (int k = 0; k < 9; k++) begin
			opl[k] = '0;
			opr[k] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			opl[i] = av[i];
			opr[i] = bv[i];
		end
		case (op_in)
			OP_SCALE: begin
				for (int i = 0; i < 3; i++) opr[i] = item.scale_factor;
			end
			OP_CROSS, OP_TRIPLE: begin
				opl[0] = uv[1]; opr[0] = wv[2];
				opl[1] = uv[2]; opr[1] = wv[1];
				opl[2] = uv[2]; opr[2] = wv[0];
				opl[3] = uv[0]; opr[3] = wv[2];
				opl[4] = uv[0]; opr[4] = wv[1];
				opl[5] = uv[1]; opr[5] = wv[0];
			end
			OP_XFORM: begin
				// product 3j+i is a_i times coefficient (row i, column j)
				for (int j = 0; j < 3; j++) begin
					for (int i = 0; i < 3; i++) begin
						opl[3*j+i] = av[i];
						opr[3*j+i] = {{(DATA_W-COEF_W){row_q[i][COEF_W*j+COEF_W-1]}},
							row_q[i][COEF_W*j +: COEF_W]};
					end
				end
			end
			default: ;
		endcase
	end

	op_t                      op_s1;
	logic signed [DATA_W-1:0] opl_s1 [9];
	logic signed [DATA_W-1:0] opr_s1 [9];
	logic signed [DATA_W-1:0] a_s1 [3];

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1  <= op_in;
			opl_s1 <= opl;
			opr_s1 <= opr;
			a_s1   <= av;
		end
	end

	// first multiplier bank, plus the linear ops
	logic signed [PROD_W-1:0] p_s2 [9];
	logic signed [DATA_W:0]   lin [3];
	logic signed [DATA_W:0]   lin_s2 [3];
	op_t                      op_s2;
	logic signed [DATA_W-1:0] a_s2 [3];

	v3a_mul_bank #(.N(9)) u_mul1 (
		.clk  (clk),
		.en   (en2),
		.opa  (opl_s1),
		.opb  (opr_s1),
		.prod (p_s2)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (op_s1)
				OP_NEG:  lin[i] = -{opl_s1[i][DATA_W-1], opl_s1[i]};
				OP_SUB:  lin[i] = {opl_s1[i][DATA_W-1], opl_s1[i]}
					- {opr_s1[i][DATA_W-1], opr_s1[i]};
				default: lin[i] = {opl_s1[i][DATA_W-1], opl_s1[i]}
					+ {opr_s1[i][DATA_W-1], opr_s1[i]};
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2  <= op_s1;
			lin_s2 <= lin;
			a_s2   <= a_s1;
		end
	end

	// sums and clamps
	logic signed [PROD_W-1:0] shp [9];
	logic        [SUM_W-1:0]  sh [9];
	logic        [SUM_W-1:0]  sum2 [4];
	sat_t                     sr2 [4];
	sat_t                     sx2 [3];
	logic        [DATA_W-1:0] r2 [3];
	logic        [DATA_W-1:0] s2;
	logic                     f2;

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			shp[k] = (op_s2 == OP_XFORM) ? (p_s2[k] >>> M_SHIFT) : (p_s2[k] >>> Q_SHIFT);
			sh[k]  = shp[k][SUM_W-1:0];
		end
		sx2[0] = sat32(sh[0] - sh[1]);
		sx2[1] = sat32(sh[2] - sh[3]);
		sx2[2] = sat32(sh[4] - sh[5]);
		for (int i = 0; i < 3; i++) begin
			case (op_s2)
				OP_SCALE: sum2[i] = sh[i];
				OP_XFORM: sum2[i] = sh[3*i] + sh[3*i+1] + sh[3*i+2];
				default:  sum2[i] = {{(SUM_W-DATA_W-1){lin_s2[i][DATA_W]}}, lin_s2[i]};
			endcase
			sr2[i] = sat32(sum2[i]);
		end
		sum2[3] = sh[0] + sh[1] + sh[2];
		sr2[3]  = sat32(sum2[3]);
		r2[0] = '0;
		r2[1] = '0;
		r2[2] = '0;
		s2    = '0;
		f2    = 1'b0;
		case (op_s2)
			OP_DOT: begin
				s2 = sr2[3].val;
				f2 = sr2[3].clip;
			end
			OP_CROSS: begin
				for (int i = 0; i < 3; i++) r2[i] = sx2[i].val;
				f2 = sx2[0].clip | sx2[1].clip | sx2[2].clip;
			end
			OP_TRIPLE: begin
				f2 = sx2[0].clip | sx2[1].clip | sx2[2].clip;
			end
			default: begin
				for (int i = 0; i < 3; i++) r2[i] = sr2[i].val;
				f2 = sr2[0].clip | sr2[1].clip | sr2[2].clip;
			end
		endcase
	end

	logic        [DATA_W-1:0] r_s3 [3];
	logic        [DATA_W-1:0] s_s3;
	logic                     f_s3;
	logic                     trip_s3;
	logic signed [DATA_W-1:0] x_s3 [3];
	logic signed [DATA_W-1:0] a_s3 [3];

	always_ff @(posedge clk) begin
		if (en3) begin
			r_s3    <= r2;
			s_s3    <= s2;
			f_s3    <= f2;
			trip_s3 <= (op_s2 == OP_TRIPLE);
			for (int i = 0; i < 3; i++) x_s3[i] <= sx2[i].val;
			a_s3    <= a_s2;
		end
	end

	// second multiplier bank: a . (b x c)
	logic signed [PROD_W-1:0] q_s4 [3];
	logic        [DATA_W-1:0] r_s4 [3];
	logic        [DATA_W-1:0] s_s4;
	logic                     f_s4;
	logic                     trip_s4;

	v3a_mul_bank #(.N(3)) u_mul2 (
		.clk  (clk),
		.en   (en4),
		.opa  (a_s3),
		.opb  (x_s3),
		.prod (q_s4)
	);

	always_ff @(posedge clk) begin
		if (en4) begin
			r_s4    <= r_s3;
			s_s4    <= s_s3;
			f_s4    <= f_s3;
			trip_s4 <= trip_s3;
		end
	end

	logic signed [PROD_W-1:0] shq [3];
	logic        [SUM_W-1:0]  sum4;
	sat_t                     sr4;
	logic        [DATA_W-1:0] s4;
	logic                     f4;

	always_comb begin
		for (int i = 0; i < 3; i++) shq[i] = q_s4[i] >>> Q_SHIFT;
		sum4 = shq[0][SUM_W-1:0] + shq[1][SUM_W-1:0] + shq[2][SUM_W-1:0];
		sr4  = sat32(sum4);
		s4   = trip_s4 ? sr4.val : s_s4;
		f4   = f_s4 | (trip_s4 & sr4.clip);
	end

	// output register
	logic [DATA_W-1:0] r_s5 [3];
	logic [DATA_W-1:0] s_s5;
	logic              f_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			r_s5 <= r_s4;
			s_s5 <= s4;
			f_s5 <= f4;
		end
	end

	assign result.valid         = v_s5;
	assign result.result_x      = r_s5[0];
	assign result.result_y      = r_s5[1];
	assign result.result_z      = r_s5[2];
	assign result.scalar_result = s_s5;
	assign result.saturated     = f_s5;

endmodule

// File: tb/sv/vector3_alu_with_transform_core_tb.sv
module vector3_alu_with_transform_core_tb;
	import v3a_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY         = 5;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int N_PHASE         = 8;
	localparam int ITEMS_PER_PHASE = 190;
	localparam int QUIET_PHASE     = 5;

	// cfg_index value past the last matrix row, must be ignored
	localparam logic [1:0] REG_NONE = 2'd3;

	localparam logic [31:0] MAXV    = 32'h7FFF_FFFF;
	localparam logic [31:0] MINV    = 32'h8000_0000;
	localparam logic [31:0] ZERO    = 32'h0000_0000;
	localparam logic [31:0] ONE     = 32'h0001_0000;
	localparam logic [31:0] TWO     = 32'h0002_0000;
	localparam logic [31:0] THREE   = 32'h0003_0000;
	localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	typedef struct packed {
		op_t         op;
		logic [31:0] ax, ay, az;
		logic [31:0] bx, by, bz;
		logic [31:0] cx, cy, cz;
		logic [31:0] k;
	} vec_item_t;

	typedef struct packed {
		logic [31:0] rx, ry, rz;
		logic [31:0] sc;
		logic        sat;
	} vec_res_t;

	typedef struct {
		vec_item_t it;
		logic      typed;
		vec_res_t  res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [ROW_W-1:0] cfg_data;

	v3a_in_if  item_ch();
	v3a_out_if result_ch();

	vector3_alu_with_transform_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [ROW_W-1:0] mat_row [3];
	vec_res_t pending_results [$];
	stim_row_t dir_rows [$];
	bit quiet;
	int errors;
	int n_items;
	int n_checked;
	int n_sat;
	int n_settings;
	int op_cnt [8];
	int cycles;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("vector3_alu_with_transform_core_tb NOT OK");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	function automatic longint clamp32(input longint v, inout bit f);
		if (v > SAT_HI) begin
			f = 1'b1;
			return SAT_HI;
		end
		if (v < SAT_LO) begin
			f = 1'b1;
			return SAT_LO;
		end
		return v;
	endfunction

	function automatic longint fxmul(input longint a, input longint b, input int sh);
		return (a * b) >>> sh;
	endfunction

	function automatic void cross3(input longint u[3], input longint v[3],
			output longint w[3], inout bit f);
		w[0] = clamp32(fxmul(u[1], v[2], Q_SHIFT) - fxmul(u[2], v[1], Q_SHIFT), f);
		w[1] = clamp32(fxmul(u[2], v[0], Q_SHIFT) - fxmul(u[0], v[2], Q_SHIFT), f);
		w[2] = clamp32(fxmul(u[0], v[1], Q_SHIFT) - fxmul(u[1], v[0], Q_SHIFT), f);
	endfunction

	function automatic vec_res_t alu_predict(input vec_item_t it);
		longint av[3], bv[3], cv[3], vec[3], bxc[3];
		longint kv, sc, acc;
		bit f;
		int i, j;
		vec_res_t r;
		av[0] = longint'($signed(it.ax));
		av[1] = longint'($signed(it.ay));
		av[2] = longint'($signed(it.az));
		bv[0] = longint'($signed(it.bx));
		bv[1] = longint'($signed(it.by));
		bv[2] = longint'($signed(it.bz));
		cv[0] = longint'($signed(it.cx));
		cv[1] = longint'($signed(it.cy));
		cv[2] = longint'($signed(it.cz));
		kv = longint'($signed(it.k));
		vec = '{0, 0, 0};
		sc = 0;
		f = 1'b0;
		case (it.op)
			OP_NEG: begin
				for (i = 0; i < 3; i++) vec[i] = clamp32(-av[i], f);
			end
			OP_ADD: begin
				for (i = 0; i < 3; i++) vec[i] = clamp32(av[i] + bv[i], f);
			end
			OP_SUB: begin
				for (i = 0; i < 3; i++) vec[i] = clamp32(av[i] - bv[i], f);
			end
			OP_SCALE: begin
				for (i = 0; i < 3; i++) vec[i] = clamp32(fxmul(av[i], kv, Q_SHIFT), f);
			end
			OP_DOT: begin
				sc = clamp32(fxmul(av[0], bv[0], Q_SHIFT) + fxmul(av[1], bv[1], Q_SHIFT)
					+ fxmul(av[2], bv[2], Q_SHIFT), f);
			end
			OP_CROSS: begin
				cross3(av, bv, vec, f);
			end
			OP_TRIPLE: begin
				// clamps inside b x c count toward the flag as well
				cross3(bv, cv, bxc, f);
				sc = clamp32(fxmul(av[0], bxc[0], Q_SHIFT) + fxmul(av[1], bxc[1], Q_SHIFT)
					+ fxmul(av[2], bxc[2], Q_SHIFT), f);
			end
			default: begin
				// row vector times matrix: column i takes coefficient i of every row
				for (i = 0; i < 3; i++) begin
					acc = 0;
					for (j = 0; j < 3; j++)
						acc += fxmul(av[j], longint'($signed(mat_row[j][COEF_W*i +: COEF_W])),
							M_SHIFT);
					vec[i] = clamp32(acc, f);
				end
			end
		endcase
		r.rx = vec[0][31:0];
		r.ry = vec[1][31:0];
		r.rz = vec[2][31:0];
		r.sc = sc[31:0];
		r.sat = f;
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic logic [31:0] rand_word();
		case ($urandom_range(9))
			0: return MINV;
			1: return MAXV;
			2: return ZERO;
			3, 4, 5: return $urandom;
			default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(6))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h4000;
			3: return 16'hC000;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic vec_item_t vi(input op_t op,
			input logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz, k);
		vec_item_t it;
		it.op = op;
		it.ax = ax;
		it.ay = ay;
		it.az = az;
		it.bx = bx;
		it.by = by;
		it.bz = bz;
		it.cx = cx;
		it.cy = cy;
		it.cz = cz;
		it.k = k;
		return it;
	endfunction

	function automatic vec_res_t vr(input logic [31:0] rx, ry, rz, sc, input logic sat);
		vec_res_t r;
		r.rx = rx;
		r.ry = ry;
		r.rz = rz;
		r.sc = sc;
		r.sat = sat;
		return r;
	endfunction

	function automatic vec_item_t rand_item();
		return vi(op_t'($urandom_range(7)), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
			rand_word());
	endfunction

	task automatic send_item(input vec_item_t it, input logic typed, input vec_res_t res);
		while (!quiet && $urandom_range(99) < 9) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= it.op;
		item_ch.a_x <= it.ax;
		item_ch.a_y <= it.ay;
		item_ch.a_z <= it.az;
		item_ch.b_x <= it.bx;
		item_ch.b_y <= it.by;
		item_ch.b_z <= it.bz;
		item_ch.c_x <= it.cx;
		item_ch.c_y <= it.cy;
		item_ch.c_z <= it.cz;
		item_ch.scale_factor <= it.k;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		pending_results.push_back(typed ? res : alu_predict(it));
		op_cnt[it.op]++;
		n_items++;
	endtask

	// hold off the sender until every result is back, then let the pipe settle
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [ROW_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			REG_ROW0: mat_row[0] = d;
			REG_ROW1: mat_row[1] = d;
			REG_ROW2: mat_row[2] = d;
			default: ;
		endcase
	endtask

	task automatic load_matrix(input int phase);
		logic [ROW_W-1:0] rows [3];
		int r;
		for (r = 0; r < 3; r++) begin
			case (phase)
				0: rows[r] = '0;
				1: rows[r] = {3{16'h8000}};
				2: rows[r] = {3{16'h7FFF}};
				3: rows[r] = '1;
				default: rows[r] = {rand_coef(), rand_coef(), rand_coef()};
			endcase
		end
		cfg_write(REG_ROW0, rows[0]);
		cfg_write(REG_NONE, ROW_W'({$urandom, $urandom}));
		cfg_write(REG_ROW1, rows[1]);
		cfg_write(REG_ROW2, rows[2]);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	// ---------------- result side ----------------

	always @(posedge clk) begin
		vec_res_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_x", want.rx, result_ch.result_x);
				check_field("result_y", want.ry, result_ch.result_y);
				check_field("result_z", want.rz, result_ch.result_z);
				check_field("scalar_result", want.sc, result_ch.scalar_result);
				check_field("saturated", {31'd0, want.sat}, {31'd0, result_ch.saturated});
				n_checked++;
				if (want.sat) n_sat++;
			end
		end
		result_ch.ready <= quiet || ($urandom_range(99) >= 9);
	end

	// ---------------- main sequence ----------------

	initial begin
		int p, n;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ROW0;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.operation <= OP_NEG;
		item_ch.a_x <= '0;
		item_ch.a_y <= '0;
		item_ch.a_z <= '0;
		item_ch.b_x <= '0;
		item_ch.b_y <= '0;
		item_ch.b_z <= '0;
		item_ch.c_x <= '0;
		item_ch.c_y <= '0;
		item_ch.c_z <= '0;
		item_ch.scale_factor <= '0;
		mat_row[0] = ROW0_RST;
		mat_row[1] = ROW1_RST;
		mat_row[2] = ROW2_RST;
		quiet = 1'b0;
		errors = 0;
		n_settings = 1;

		// directed rows, run on the identity matrix left by reset;
		// operands an operation ignores are random in the rows with a typed result
		dir_rows.push_back('{vi(OP_NEG, ONE, NEG_ONE, ZERO, rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), rand_word()), 1'b1,
			vr(NEG_ONE, ONE, ZERO, ZERO, 1'b0)});
		// negating the most negative value clamps
		dir_rows.push_back('{vi(OP_NEG, MINV, MAXV, ZERO, rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), rand_word()), 1'b1,
			vr(MAXV, 32'h8000_0001, ZERO, ZERO, 1'b1)});
		dir_rows.push_back('{vi(OP_ADD, MAXV, MINV, ONE, MAXV, MINV, NEG_ONE, rand_word(),
			rand_word(), rand_word(), rand_word()), 1'b1, vr(MAXV, MINV, ZERO, ZERO, 1'b1)});
		dir_rows.push_back('{vi(OP_ADD, rand_word(), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), ZERO, ZERO, ZERO, ZERO), 1'b0, '0});
		dir_rows.push_back('{vi(OP_SUB, MINV, MAXV, ZERO, MAXV, MINV, ZERO, rand_word(),
			rand_word(), rand_word(), rand_word()), 1'b1, vr(MINV, MAXV, ZERO, ZERO, 1'b1)});
		dir_rows.push_back('{vi(OP_SUB, rand_word(), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), ZERO, ZERO, ZERO, ZERO), 1'b0, '0});
		dir_rows.push_back('{vi(OP_SCALE, ONE, NEG_ONE, MAXV, rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), ONE), 1'b1,
			vr(ONE, NEG_ONE, MAXV, ZERO, 1'b0)});
		dir_rows.push_back('{vi(OP_SCALE, MINV, MAXV, ONE, rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), ZERO), 1'b1,
			vr(ZERO, ZERO, ZERO, ZERO, 1'b0)});
		dir_rows.push_back('{vi(OP_SCALE, MINV, MAXV, NEG_ONE, ZERO, ZERO, ZERO, ZERO, ZERO,
			ZERO, MINV), 1'b0, '0});
		dir_rows.push_back('{vi(OP_DOT, ONE, ONE, ONE, ONE, TWO, THREE, rand_word(),
			rand_word(), rand_word(), rand_word()), 1'b1,
			vr(ZERO, ZERO, ZERO, 32'h0006_0000, 1'b0)});
		dir_rows.push_back('{vi(OP_DOT, MINV, MINV, MINV, MINV, MINV, MINV, rand_word(),
			rand_word(), rand_word(), rand_word()), 1'b1, vr(ZERO, ZERO, ZERO, MAXV, 1'b1)});
		dir_rows.push_back('{vi(OP_DOT, MINV, MAXV, MINV, MAXV, MINV, MAXV, ZERO, ZERO, ZERO,
			ZERO), 1'b0, '0});
		dir_rows.push_back('{vi(OP_CROSS, ONE, ZERO, ZERO, ZERO, ONE, ZERO, rand_word(),
			rand_word(), rand_word(), rand_word()), 1'b1, vr(ZERO, ZERO, ONE, ZERO, 1'b0)});
		dir_rows.push_back('{vi(OP_CROSS, MAXV, MINV, MAXV, MINV, MAXV, MINV, ZERO, ZERO, ZERO,
			ZERO), 1'b0, '0});
		dir_rows.push_back('{vi(OP_TRIPLE, ONE, ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE,
			rand_word()), 1'b1, vr(ZERO, ZERO, ZERO, ONE, 1'b0)});
		// a clamp inside b x c sets the flag even though the final sum is zero
		dir_rows.push_back('{vi(OP_TRIPLE, ZERO, ZERO, ZERO, MINV, ZERO, ZERO, ZERO, MINV,
			ZERO, rand_word()), 1'b1, vr(ZERO, ZERO, ZERO, ZERO, 1'b1)});
		dir_rows.push_back('{vi(OP_TRIPLE, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV,
			MINV, ZERO), 1'b0, '0});
		dir_rows.push_back('{vi(OP_XFORM, MINV, MAXV, ONE, rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), rand_word()), 1'b1,
			vr(MINV, MAXV, ONE, ZERO, 1'b0)});
		dir_rows.push_back('{vi(OP_XFORM, ZERO, ZERO, ZERO, rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), rand_word()), 1'b1,
			vr(ZERO, ZERO, ZERO, ZERO, 1'b0)});
		for (n = 0; n < 4; n++) begin
			dir_rows.push_back('{rand_item(), 1'b0, '0});
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

		for (p = 0; p < N_PHASE; p++) begin
			drain();
			load_matrix(p);
			quiet = (p == QUIET_PHASE);
			// push the matrix extremes through the transform first
			send_item(vi(OP_XFORM, MAXV, MAXV, MAXV, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom), 1'b0, '0);
			send_item(vi(OP_XFORM, MINV, MINV, MINV, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom), 1'b0, '0);
			send_item(vi(OP_XFORM, MAXV, MINV, MAXV, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom), 1'b0, '0);
			for (n = 0; n < ITEMS_PER_PHASE; n++) send_item(rand_item(), 1'b0, '0);
		end
		quiet = 1'b0;
		drain();
		repeat (4 * LATENCY) @(posedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		$display("%0d items sent over %0d matrix settings, %0d results checked, %0d saturated",
			n_items, n_settings, n_checked, n_sat);
		$display("per op neg/add/sub/scale/dot/cross/triple/xform: %0d %0d %0d %0d %0d %0d %0d %0d",
			op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3], op_cnt[4], op_cnt[5], op_cnt[6],
			op_cnt[7]);
		if (errors == 0) begin
			$display("vector3_alu_with_transform_core_tb OK");
		end else begin
			$display("vector3_alu_with_transform_core_tb NOT OK");
		end
		$finish;
	end

endmodule
